/* design/erj_pkg.sv */
// Shared constants and types for the ellipsoid residual and Jacobian row block.
`default_nettype none

package erj_pkg;

  // Fixed point setup.
  localparam int COEF_FRAC   = 40;
  localparam int SAMPLE_BITS = 16;

  // Port field widths.
  localparam int IN_W       = 16;
  localparam int CENTER_W   = 16;
  localparam int COEF_W     = 32;
  localparam int RES_W      = 48;
  localparam int GA_W       = 34;
  localparam int GC_W       = 52;
  localparam int GX_W       = 36;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 48;

  // Internal datapath widths.
  localparam int OFS_W   = ((SAMPLE_BITS > CENTER_W) ? SAMPLE_BITS : CENTER_W) + 1;
  localparam int SQ_W    = 2 * OFS_W;
  localparam int CROSS_W = SQ_W + 1;
  localparam int CP_W    = COEF_W + OFS_W;
  localparam int GS_W    = CP_W + 2;
  localparam int RP_W    = COEF_W + CROSS_W;
  localparam int PAIR_W  = RP_W + 1;
  localparam int SUM_W   = PAIR_W + 3;

  // Residual rescale to 32 fraction bits.
  localparam int RES_SHIFT = COEF_FRAC - 32;
  localparam int RSH       = (RES_SHIFT > 0) ? RES_SHIFT : 0;
  localparam int LSH       = (RES_SHIFT < 0) ? -RES_SHIFT : 0;
  localparam int SH_W      = SUM_W + LSH;

  // Register stages from accepted sample to result strobe.
  localparam int PIPE_DEPTH = 6;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_CENTER   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_A   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_B   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_C   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CROSS_UV = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CROSS_UW = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_CROSS_VW = 3'd6;

  // Ellipsoid model as seen by the datapath.
  typedef struct packed {
    logic signed [CENTER_W-1:0] center_x;
    logic signed [CENTER_W-1:0] center_y;
    logic signed [CENTER_W-1:0] center_z;
    logic signed [COEF_W-1:0]   coef_a;
    logic signed [COEF_W-1:0]   coef_b;
    logic signed [COEF_W-1:0]   coef_c;
    logic signed [COEF_W-1:0]   cross_uv;
    logic signed [COEF_W-1:0]   cross_uw;
    logic signed [COEF_W-1:0]   cross_vw;
  } erj_model_t;

  // Jacobian row fields carried alongside the residual.
  typedef struct packed {
    logic        [GA_W-1:0] coef_a;
    logic        [GA_W-1:0] coef_b;
    logic        [GA_W-1:0] coef_c;
    logic signed [GC_W-1:0] center_x;
    logic signed [GC_W-1:0] center_y;
    logic signed [GC_W-1:0] center_z;
    logic signed [GX_W-1:0] cross_uv;
    logic signed [GX_W-1:0] cross_uw;
    logic signed [GX_W-1:0] cross_vw;
  } erj_grad_t;

endpackage

`default_nettype wire

/* design/erj_datapath.sv */
// Six-stage residual and Jacobian pipeline for one sample per cycle.
`default_nettype none

module erj_datapath
  import erj_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_valid,
  input  wire logic [IN_W-1:0]         in_sample_x,
  input  wire logic [IN_W-1:0]         in_sample_y,
  input  wire logic [IN_W-1:0]         in_sample_z,
  input  wire erj_model_t              model,
  output logic                         out_valid,
  output logic signed [RES_W-1:0]      out_residual,
  output erj_grad_t                    out_grad
);

  localparam logic signed [SUM_W-1:0] RES_ONE = SUM_W'(1) << COEF_FRAC;
  localparam logic signed [RES_W-1:0] RES_MAX = {1'b0, {(RES_W-1){1'b1}}};
  localparam logic signed [RES_W-1:0] RES_MIN = {1'b1, {(RES_W-1){1'b0}}};

  // Valid bits travel with the data.
  logic [PIPE_DEPTH-1:0] vld_r, vld_nxt;

  // Stage 1: offsets from the center.
  logic signed [OFS_W-1:0] sx, sy, sz;
  logic signed [OFS_W-1:0] u_r, v_r, w_r, u_nxt, v_nxt, w_nxt;

  // Stage 2: squares, cross products and center-gradient products.
  logic signed [SQ_W-1:0] uu_r, vv_r, ww_r, uv_r, uw_r, vw_r;
  logic signed [SQ_W-1:0] uu_nxt, vv_nxt, ww_nxt, uv_nxt, uw_nxt, vw_nxt;
  logic signed [CP_W-1:0] cp_r [9];
  logic signed [CP_W-1:0] cp_nxt [9];

  // Stage 3: residual terms and the finished gradients.
  logic signed [CROSS_W-1:0] uv2, uw2, vw2;
  logic signed [GS_W-1:0]    gsum_x, gsum_y, gsum_z;
  logic signed [RP_W-1:0]    rp_r [6];
  logic signed [RP_W-1:0]    rp_nxt [6];
  erj_grad_t                 g3_r, g3_nxt;

  // Stage 4: pair sums.
  logic signed [PAIR_W-1:0] q_r [3];
  logic signed [PAIR_W-1:0] q_nxt [3];
  erj_grad_t                g4_r;

  // Stage 5: full sum minus one.
  logic signed [SUM_W-1:0] tot_r, tot_nxt;
  erj_grad_t               g5_r;

  // Stage 6: rescale and saturate.
  logic signed [SH_W-1:0]          sh_in, shifted;
  logic        [SH_W-RES_W:0]      sh_hi;
  logic signed [RES_W-1:0]         res_r, res_nxt;
  erj_grad_t                       g6_r;

  // Valid pipe.
  always_comb begin
    vld_nxt = {vld_r[PIPE_DEPTH-2:0], in_valid};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // Stage 1 logic.
  always_comb begin
    sx    = OFS_W'($signed(in_sample_x[SAMPLE_BITS-1:0]));
    sy    = OFS_W'($signed(in_sample_y[SAMPLE_BITS-1:0]));
    sz    = OFS_W'($signed(in_sample_z[SAMPLE_BITS-1:0]));
    u_nxt = sx - OFS_W'(model.center_x);
    v_nxt = sy - OFS_W'(model.center_y);
    w_nxt = sz - OFS_W'(model.center_z);
  end

  // Stage 2 logic: one multiplier per product.
  always_comb begin
    uu_nxt    = u_r * u_r;
    vv_nxt    = v_r * v_r;
    ww_nxt    = w_r * w_r;
    uv_nxt    = u_r * v_r;
    uw_nxt    = u_r * w_r;
    vw_nxt    = v_r * w_r;
    cp_nxt[0] = model.coef_a   * u_r;
    cp_nxt[1] = model.cross_uv * v_r;
    cp_nxt[2] = model.cross_uw * w_r;
    cp_nxt[3] = model.coef_b   * v_r;
    cp_nxt[4] = model.cross_uv * u_r;
    cp_nxt[5] = model.cross_vw * w_r;
    cp_nxt[6] = model.coef_c   * w_r;
    cp_nxt[7] = model.cross_uw * u_r;
    cp_nxt[8] = model.cross_vw * v_r;
  end

  // Stage 3 logic: coefficient times square products and center gradients.
  always_comb begin
    uv2       = $signed({uv_r, 1'b0});
    uw2       = $signed({uw_r, 1'b0});
    vw2       = $signed({vw_r, 1'b0});
    rp_nxt[0] = model.coef_a   * uu_r;
    rp_nxt[1] = model.coef_b   * vv_r;
    rp_nxt[2] = model.coef_c   * ww_r;
    rp_nxt[3] = model.cross_uv * uv2;
    rp_nxt[4] = model.cross_uw * uw2;
    rp_nxt[5] = model.cross_vw * vw2;
    gsum_x = GS_W'(cp_r[0]) + GS_W'(cp_r[1]) + GS_W'(cp_r[2]);
    gsum_y = GS_W'(cp_r[3]) + GS_W'(cp_r[4]) + GS_W'(cp_r[5]);
    gsum_z = GS_W'(cp_r[6]) + GS_W'(cp_r[7]) + GS_W'(cp_r[8]);
    g3_nxt.coef_a   = GA_W'(uu_r);
    g3_nxt.coef_b   = GA_W'(vv_r);
    g3_nxt.coef_c   = GA_W'(ww_r);
    g3_nxt.center_x = -GC_W'($signed({gsum_x, 1'b0}));
    g3_nxt.center_y = -GC_W'($signed({gsum_y, 1'b0}));
    g3_nxt.center_z = -GC_W'($signed({gsum_z, 1'b0}));
    g3_nxt.cross_uv = GX_W'(uv2);
    g3_nxt.cross_uw = GX_W'(uw2);
    g3_nxt.cross_vw = GX_W'(vw2);
  end

  // Stage 4 and 5 logic: adder tree, then subtract one.
  always_comb begin
    q_nxt[0] = PAIR_W'(rp_r[0]) + PAIR_W'(rp_r[1]);
    q_nxt[1] = PAIR_W'(rp_r[2]) + PAIR_W'(rp_r[3]);
    q_nxt[2] = PAIR_W'(rp_r[4]) + PAIR_W'(rp_r[5]);
    tot_nxt  = SUM_W'(q_r[0]) + SUM_W'(q_r[1]) + SUM_W'(q_r[2]) - RES_ONE;
  end

  // Stage 6 logic: arithmetic rescale to 32 fraction bits, then clamp.
  always_comb begin
    sh_in   = SH_W'(tot_r);
    shifted = (RES_SHIFT >= 0) ? (sh_in >>> RSH) : (sh_in <<< LSH);
    sh_hi   = shifted[SH_W-1:RES_W-1];
    if ((&sh_hi) || !(|sh_hi)) begin
      res_nxt = shifted[RES_W-1:0];
    end else if (shifted[SH_W-1]) begin
      res_nxt = RES_MIN;
    end else begin
      res_nxt = RES_MAX;
    end
  end

  // Payload registers, no reset needed.
  always_ff @(posedge clk) begin
    u_r   <= u_nxt;
    v_r   <= v_nxt;
    w_r   <= w_nxt;
    uu_r  <= uu_nxt;
    vv_r  <= vv_nxt;
    ww_r  <= ww_nxt;
    uv_r  <= uv_nxt;
    uw_r  <= uw_nxt;
    vw_r  <= vw_nxt;
    cp_r  <= cp_nxt;
    rp_r  <= rp_nxt;
    g3_r  <= g3_nxt;
    q_r   <= q_nxt;
    g4_r  <= g3_r;
    tot_r <= tot_nxt;
    g5_r  <= g4_r;
    res_r <= res_nxt;
    g6_r  <= g5_r;
  end

  assign out_valid    = vld_r[PIPE_DEPTH-1];
  assign out_residual = res_r;
  assign out_grad     = g6_r;

endmodule

`default_nettype wire

/* design/ellipsoid_residual_jacobian_row_top.sv */
// Top level: configuration registers, command handshake and result ports.
// Path: a sample accepted at a clock edge passes six register stages, the first
// loaded at the accepting edge, and its result is strobed from the last.
// Throughput: one sample per cycle; busy is never raised and results are
// strobed once, since the receiver cannot stall.
// Reset (synchronous, active low) empties the pipeline and zeroes the model.
`default_nettype none

module ellipsoid_residual_jacobian_row_top
  import erj_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    start,
  output logic                         busy,
  input  wire logic [IN_W-1:0]         in_sample_x,
  input  wire logic [IN_W-1:0]         in_sample_y,
  input  wire logic [IN_W-1:0]         in_sample_z,
  input  wire logic                    cfg_valid,
  output logic                         cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [CFG_DATA_W-1:0]   cfg_data,
  output logic                         out_valid,
  output logic [RES_W-1:0]             out_residual,
  output logic [GA_W-1:0]              out_grad_coef_a,
  output logic [GA_W-1:0]              out_grad_coef_b,
  output logic [GA_W-1:0]              out_grad_coef_c,
  output logic [GC_W-1:0]              out_grad_center_x,
  output logic [GC_W-1:0]              out_grad_center_y,
  output logic [GC_W-1:0]              out_grad_center_z,
  output logic [GX_W-1:0]              out_grad_cross_uv,
  output logic [GX_W-1:0]              out_grad_cross_uw,
  output logic [GX_W-1:0]              out_grad_cross_vw
);

  logic [CFG_DATA_W-1:0] center_r, center_nxt;
  logic [COEF_W-1:0]     coef_a_r, coef_a_nxt;
  logic [COEF_W-1:0]     coef_b_r, coef_b_nxt;
  logic [COEF_W-1:0]     coef_c_r, coef_c_nxt;
  logic [COEF_W-1:0]     cross_uv_r, cross_uv_nxt;
  logic [COEF_W-1:0]     cross_uw_r, cross_uw_nxt;
  logic [COEF_W-1:0]     cross_vw_r, cross_vw_nxt;
  logic                  cfg_wr;
  logic                  in_xfer;
  erj_model_t            model;
  logic signed [RES_W-1:0] res;
  erj_grad_t             grad;

  // The pipeline never stalls, so both sides are always ready.
  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign in_xfer   = start && !busy;

  // Register write decode; an index past the list is dropped.
  always_comb begin
    center_nxt   = center_r;
    coef_a_nxt   = coef_a_r;
    coef_b_nxt   = coef_b_r;
    coef_c_nxt   = coef_c_r;
    cross_uv_nxt = cross_uv_r;
    cross_uw_nxt = cross_uw_r;
    cross_vw_nxt = cross_vw_r;
    if (cfg_wr) begin
      case (cfg_index)
        REG_CENTER:   center_nxt   = cfg_data;
        REG_COEF_A:   coef_a_nxt   = cfg_data[COEF_W-1:0];
        REG_COEF_B:   coef_b_nxt   = cfg_data[COEF_W-1:0];
        REG_COEF_C:   coef_c_nxt   = cfg_data[COEF_W-1:0];
        REG_CROSS_UV: cross_uv_nxt = cfg_data[COEF_W-1:0];
        REG_CROSS_UW: cross_uw_nxt = cfg_data[COEF_W-1:0];
        REG_CROSS_VW: cross_vw_nxt = cfg_data[COEF_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_r   <= '0;
      coef_a_r   <= '0;
      coef_b_r   <= '0;
      coef_c_r   <= '0;
      cross_uv_r <= '0;
      cross_uw_r <= '0;
      cross_vw_r <= '0;
    end else begin
      center_r   <= center_nxt;
      coef_a_r   <= coef_a_nxt;
      coef_b_r   <= coef_b_nxt;
      coef_c_r   <= coef_c_nxt;
      cross_uv_r <= cross_uv_nxt;
      cross_uw_r <= cross_uw_nxt;
      cross_vw_r <= cross_vw_nxt;
    end
  end

  // Unpack the model for the datapath.
  always_comb begin
    model.center_x = center_r[CENTER_W-1:0];
    model.center_y = center_r[2*CENTER_W-1:CENTER_W];
    model.center_z = center_r[3*CENTER_W-1:2*CENTER_W];
    model.coef_a   = coef_a_r;
    model.coef_b   = coef_b_r;
    model.coef_c   = coef_c_r;
    model.cross_uv = cross_uv_r;
    model.cross_uw = cross_uw_r;
    model.cross_vw = cross_vw_r;
  end

  erj_datapath u_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_xfer),
    .in_sample_x  (in_sample_x),
    .in_sample_y  (in_sample_y),
    .in_sample_z  (in_sample_z),
    .model        (model),
    .out_valid    (out_valid),
    .out_residual (res),
    .out_grad     (grad)
  );

  // Result fields.
  assign out_residual      = res;
  assign out_grad_coef_a   = grad.coef_a;
  assign out_grad_coef_b   = grad.coef_b;
  assign out_grad_coef_c   = grad.coef_c;
  assign out_grad_center_x = grad.center_x;
  assign out_grad_center_y = grad.center_y;
  assign out_grad_center_z = grad.center_z;
  assign out_grad_cross_uv = grad.cross_uv;
  assign out_grad_cross_uw = grad.cross_uw;
  assign out_grad_cross_vw = grad.cross_vw;

endmodule

`default_nettype wire

/* design/erj_checker.sv */
// Port-level checks for the ellipsoid residual block and their bind.
`default_nettype none

module erj_checker
  import erj_pkg::*;
(
  input wire logic             clk,
  input wire logic             rst_n,
  input wire logic             start,
  input wire logic             busy,
  input wire logic             out_valid,
  input wire logic [GA_W-1:0]  out_grad_coef_a,
  input wire logic [GX_W-1:0]  out_grad_cross_uv,
  input wire logic [GX_W-1:0]  out_grad_cross_uw,
  input wire logic [GX_W-1:0]  out_grad_cross_vw
);

  // Every accepted sample gives a strobe once it has passed the pipeline.
  a_accept_to_result: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |-> ##PIPE_DEPTH out_valid)
    else $error("accepted sample produced no result");

  // No strobe without a matching transfer that has passed the pipeline.
  a_result_has_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, PIPE_DEPTH))
    else $error("result strobe without an accepted sample");

  // Cross derivatives are twice a product, so always even.
  a_cross_even: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !out_grad_cross_uv[0] && !out_grad_cross_uw[0] &&
                  !out_grad_cross_vw[0])
    else $error("odd cross derivative");

  // A zero x offset zeroes both cross terms that contain it.
  a_zero_u: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_grad_coef_a == '0) |->
      (out_grad_cross_uv == '0) && (out_grad_cross_uw == '0))
    else $error("cross terms nonzero with zero x offset");

endmodule

bind ellipsoid_residual_jacobian_row_top erj_checker u_erj_checker (.*);

`default_nettype wire

/* test/erj_row_checker.sv */
// Checker that predicts each residual and Jacobian row and compares it with the block's output.
`timescale 1ns / 100ps

module erj_row_checker
  import erj_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  input  wire logic                  busy,
  input  wire logic [IN_W-1:0]       in_sample_x,
  input  wire logic [IN_W-1:0]       in_sample_y,
  input  wire logic [IN_W-1:0]       in_sample_z,
  input  wire logic                  cfg_valid,
  input  wire logic                  cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  out_valid,
  input  wire logic [RES_W-1:0]      out_residual,
  input  wire logic [GA_W-1:0]       out_grad_coef_a,
  input  wire logic [GA_W-1:0]       out_grad_coef_b,
  input  wire logic [GA_W-1:0]       out_grad_coef_c,
  input  wire logic [GC_W-1:0]       out_grad_center_x,
  input  wire logic [GC_W-1:0]       out_grad_center_y,
  input  wire logic [GC_W-1:0]       out_grad_center_z,
  input  wire logic [GX_W-1:0]       out_grad_cross_uv,
  input  wire logic [GX_W-1:0]       out_grad_cross_uw,
  input  wire logic [GX_W-1:0]       out_grad_cross_vw,
  output int                         fail_count,
  output int                         pending_count
);

  // One result row: the residual and the nine Jacobian entries.
  typedef struct packed {
    logic [RES_W-1:0] residual;
    erj_grad_t        grad;
  } row_t;

  localparam logic signed [127:0] RESIDUAL_MAX = (128'sd1 <<< (RES_W - 1)) - 128'sd1;
  localparam logic signed [127:0] RESIDUAL_MIN = -(128'sd1 <<< (RES_W - 1));

  erj_model_t shadow_model;
  row_t       expected_rows[$];
  row_t       want;
  int         shown;
  int         rows_seen;

  // Exact signed product, wide enough for any coefficient times a square.
  function automatic logic signed [127:0] wide_product(longint p, longint q);
    logic signed [127:0] wp;
    logic signed [127:0] wq;
    wp = p;
    wq = q;
    return wp * wq;
  endfunction

  // Works out the row that one sample produces under the given model.
  function automatic row_t predict_row(erj_model_t m, logic [IN_W-1:0] sx,
                                       logic [IN_W-1:0] sy, logic [IN_W-1:0] sz);
    longint u, v, w;
    longint ka, kb, kc, s0, s1, s2;
    longint uu, vv, ww, uv2, uw2, vw2;
    longint gx, gy, gz;
    logic signed [127:0] acc;
    row_t row;
    u  = longint'($signed(sx[SAMPLE_BITS-1:0])) - longint'($signed(m.center_x));
    v  = longint'($signed(sy[SAMPLE_BITS-1:0])) - longint'($signed(m.center_y));
    w  = longint'($signed(sz[SAMPLE_BITS-1:0])) - longint'($signed(m.center_z));
    ka = longint'($signed(m.coef_a));
    kb = longint'($signed(m.coef_b));
    kc = longint'($signed(m.coef_c));
    s0 = longint'($signed(m.cross_uv));
    s1 = longint'($signed(m.cross_uw));
    s2 = longint'($signed(m.cross_vw));
    uu  = u * u;
    vv  = v * v;
    ww  = w * w;
    uv2 = 2 * u * v;
    uw2 = 2 * u * w;
    vw2 = 2 * v * w;
    gx  = -2 * (ka * u + s0 * v + s1 * w);
    gy  = -2 * (kb * v + s0 * u + s2 * w);
    gz  = -2 * (kc * w + s1 * u + s2 * v);

    // Model value minus one at coefficient scale, then moved to 32 fraction bits.
    acc = wide_product(ka, uu) + wide_product(kb, vv) + wide_product(kc, ww) +
          wide_product(s0, uv2) + wide_product(s1, uw2) + wide_product(s2, vw2);
    acc = acc - (128'sd1 <<< COEF_FRAC);
    if (COEF_FRAC >= 32) begin
      acc = acc >>> (COEF_FRAC - 32);
    end else begin
      acc = acc <<< (32 - COEF_FRAC);
    end
    if (acc > RESIDUAL_MAX) begin
      acc = RESIDUAL_MAX;
    end else if (acc < RESIDUAL_MIN) begin
      acc = RESIDUAL_MIN;
    end

    row.residual      = acc[RES_W-1:0];
    row.grad.coef_a   = uu[GA_W-1:0];
    row.grad.coef_b   = vv[GA_W-1:0];
    row.grad.coef_c   = ww[GA_W-1:0];
    row.grad.center_x = gx[GC_W-1:0];
    row.grad.center_y = gy[GC_W-1:0];
    row.grad.center_z = gz[GC_W-1:0];
    row.grad.cross_uv = uv2[GX_W-1:0];
    row.grad.cross_uw = uw2[GX_W-1:0];
    row.grad.cross_vw = vw2[GX_W-1:0];
    return row;
  endfunction

  // Counts a differing field and reports the first few.
  task automatic note_field(string field, logic [63:0] want_v, logic [63:0] got_v);
    if (want_v !== got_v) begin
      fail_count++;
      if (shown < 10) begin
        shown++;
        $display("%0t ns: row %0d %s expected 0x%0h, got 0x%0h",
                 $time, rows_seen, field, want_v, got_v);
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      expected_rows.delete();
      shadow_model = '0;
    end else begin
      // Result transfer: compare with the oldest row still expected.
      if (out_valid) begin
        if (expected_rows.size() == 0) begin
          fail_count++;
          if (shown < 10) begin
            shown++;
            $display("%0t ns: row %0d arrived with nothing expected", $time, rows_seen);
          end
        end else begin
          want = expected_rows.pop_front();
          note_field("residual", $unsigned(want.residual), $unsigned(out_residual));
          note_field("grad_coef_a", $unsigned(want.grad.coef_a), $unsigned(out_grad_coef_a));
          note_field("grad_coef_b", $unsigned(want.grad.coef_b), $unsigned(out_grad_coef_b));
          note_field("grad_coef_c", $unsigned(want.grad.coef_c), $unsigned(out_grad_coef_c));
          note_field("grad_center_x", $unsigned(want.grad.center_x),
                     $unsigned(out_grad_center_x));
          note_field("grad_center_y", $unsigned(want.grad.center_y),
                     $unsigned(out_grad_center_y));
          note_field("grad_center_z", $unsigned(want.grad.center_z),
                     $unsigned(out_grad_center_z));
          note_field("grad_cross_uv", $unsigned(want.grad.cross_uv),
                     $unsigned(out_grad_cross_uv));
          note_field("grad_cross_uw", $unsigned(want.grad.cross_uw),
                     $unsigned(out_grad_cross_uw));
          note_field("grad_cross_vw", $unsigned(want.grad.cross_vw),
                     $unsigned(out_grad_cross_vw));
        end
        rows_seen++;
      end

      // A sample transfer is predicted with the model as it stood before this edge.
      if (start && !busy) begin
        expected_rows.push_back(predict_row(shadow_model, in_sample_x, in_sample_y,
                                            in_sample_z));
      end

      // Register transfer; an index past the last register changes nothing.
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_CENTER: begin
            shadow_model.center_x = cfg_data[CENTER_W-1:0];
            shadow_model.center_y = cfg_data[2*CENTER_W-1:CENTER_W];
            shadow_model.center_z = cfg_data[3*CENTER_W-1:2*CENTER_W];
          end
          REG_COEF_A:   shadow_model.coef_a   = cfg_data[COEF_W-1:0];
          REG_COEF_B:   shadow_model.coef_b   = cfg_data[COEF_W-1:0];
          REG_COEF_C:   shadow_model.coef_c   = cfg_data[COEF_W-1:0];
          REG_CROSS_UV: shadow_model.cross_uv = cfg_data[COEF_W-1:0];
          REG_CROSS_UW: shadow_model.cross_uw = cfg_data[COEF_W-1:0];
          REG_CROSS_VW: shadow_model.cross_vw = cfg_data[COEF_W-1:0];
          default: ;
        endcase
      end
    end
    pending_count = expected_rows.size();
  end

endmodule

/* test/ellipsoid_residual_jacobian_row_top_tb.sv */
// Testbench top: drives samples and model registers into the block and gives the verdict.
`timescale 1ns / 100ps

module ellipsoid_residual_jacobian_row_top_tb
  import erj_pkg::*;
();

  // Register index past the end of the register file.
  localparam logic [CFG_IDX_W-1:0] REG_NONE = 3'd7;
  localparam int AXIS_MAX     = 2 ** (IN_W - 1) - 1;
  localparam int AXIS_MIN     = -(2 ** (IN_W - 1));
  localparam int RESULT_SLACK = PIPE_DEPTH + 4;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  start;
  logic                  busy;
  logic [IN_W-1:0]       in_sample_x;
  logic [IN_W-1:0]       in_sample_y;
  logic [IN_W-1:0]       in_sample_z;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  out_valid;
  logic [RES_W-1:0]      out_residual;
  logic [GA_W-1:0]       out_grad_coef_a;
  logic [GA_W-1:0]       out_grad_coef_b;
  logic [GA_W-1:0]       out_grad_coef_c;
  logic [GC_W-1:0]       out_grad_center_x;
  logic [GC_W-1:0]       out_grad_center_y;
  logic [GC_W-1:0]       out_grad_center_z;
  logic [GX_W-1:0]       out_grad_cross_uv;
  logic [GX_W-1:0]       out_grad_cross_uw;
  logic [GX_W-1:0]       out_grad_cross_vw;
  int                    fail_count;
  int                    pending_count;

  // Model currently loaded, and the radius that surface samples aim for.
  erj_model_t model_now;
  int         radius;

  always #10 clk = ~clk;

  ellipsoid_residual_jacobian_row_top i_dut (.*);

  erj_row_checker i_checker (.*);

  // Hard stop in case the block hangs.
  initial begin
    #(20_000_000);
    $display("FAILED: results differ");
    $finish;
  end

  function automatic erj_model_t make_model(logic [CENTER_W-1:0] cx, logic [CENTER_W-1:0] cy,
                                            logic [CENTER_W-1:0] cz, logic [COEF_W-1:0] a,
                                            logic [COEF_W-1:0] b, logic [COEF_W-1:0] c,
                                            logic [COEF_W-1:0] s0, logic [COEF_W-1:0] s1,
                                            logic [COEF_W-1:0] s2);
    erj_model_t m;
    m.center_x = cx;
    m.center_y = cy;
    m.center_z = cz;
    m.coef_a   = a;
    m.coef_b   = b;
    m.coef_c   = c;
    m.cross_uv = s0;
    m.cross_uw = s1;
    m.cross_vw = s2;
    return m;
  endfunction

  function automatic logic [IN_W-1:0] clamp_axis(int value);
    if (value > AXIS_MAX) return IN_W'(AXIS_MAX);
    if (value < AXIS_MIN) return IN_W'(AXIS_MIN);
    return IN_W'(value);
  endfunction

  function automatic logic [IN_W-1:0] corner_axis();
    case ($urandom_range(0, 4))
      0:       return IN_W'(AXIS_MIN);
      1:       return IN_W'(AXIS_MAX);
      2:       return '0;
      3:       return '1;
      default: return IN_W'(1);
    endcase
  endfunction

  function automatic logic [COEF_W-1:0] corner_coef();
    case ($urandom_range(0, 4))
      0:       return {1'b1, {(COEF_W - 1){1'b0}}};
      1:       return {1'b0, {(COEF_W - 1){1'b1}}};
      2:       return '0;
      3:       return '1;
      default: return COEF_W'(1);
    endcase
  endfunction

  // Upper data bits that the coefficient registers do not keep.
  function automatic logic [CFG_DATA_W-COEF_W-1:0] spare_bits();
    return (CFG_DATA_W - COEF_W)'($urandom);
  endfunction

  // Coefficient near base, spread by a random percentage.
  function automatic logic [COEF_W-1:0] scaled_coef(longint base, int lo_pct, int hi_pct);
    int pct;
    pct = int'($urandom_range(0, hi_pct - lo_pct)) + lo_pct;
    return COEF_W'(base * pct / 100);
  endfunction

  // Mostly a plausible calibration model, sometimes raw or extreme values.
  function automatic erj_model_t random_model();
    erj_model_t m;
    longint base;
    int flavor;
    flavor = $urandom_range(0, 9);
    radius = $urandom_range(64, 20000);
    if (flavor < 6) begin
      base = (longint'(1) <<< COEF_FRAC) / (longint'(radius) * radius);
      m = make_model(CENTER_W'(int'($urandom_range(0, 16000)) - 8000),
                     CENTER_W'(int'($urandom_range(0, 16000)) - 8000),
                     CENTER_W'(int'($urandom_range(0, 16000)) - 8000),
                     scaled_coef(base, 75, 125), scaled_coef(base, 75, 125),
                     scaled_coef(base, 75, 125), scaled_coef(base, -20, 20),
                     scaled_coef(base, -20, 20), scaled_coef(base, -20, 20));
    end else if (flavor < 8) begin
      m = make_model(CENTER_W'($urandom), CENTER_W'($urandom), CENTER_W'($urandom),
                     $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    end else begin
      m = make_model(corner_axis(), corner_axis(), corner_axis(), corner_coef(),
                     corner_coef(), corner_coef(), corner_coef(), corner_coef(),
                     corner_coef());
    end
    return m;
  endfunction

  // Sample close to a sphere of the current radius around the loaded center.
  task automatic surface_sample(output logic [IN_W-1:0] sx, output logic [IN_W-1:0] sy,
                                output logic [IN_W-1:0] sz);
    int du, dv, dw, jitter;
    real rest;
    du = int'($urandom_range(0, 2 * radius)) - radius;
    dv = int'($urandom_range(0, 2 * radius)) - radius;
    rest = real'(radius) * radius - real'(du) * du - real'(dv) * dv;
    if (rest < 0.0) rest = 0.0;
    dw = int'($sqrt(rest));
    if ($urandom_range(0, 1) == 1) dw = -dw;
    jitter = radius / 32 + 1;
    du += int'($urandom_range(0, 2 * jitter)) - jitter;
    dv += int'($urandom_range(0, 2 * jitter)) - jitter;
    dw += int'($urandom_range(0, 2 * jitter)) - jitter;
    sx = clamp_axis(int'($signed(model_now.center_x)) + du);
    sy = clamp_axis(int'($signed(model_now.center_y)) + dv);
    sz = clamp_axis(int'($signed(model_now.center_z)) + dw);
  endtask

  // Idle cycles before the next sample for a given pacing profile.
  function automatic int pick_gap(int profile);
    int r;
    r = $urandom_range(0, 99);
    case (profile)
      0: return 0;
      1: begin
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
      end
      default: begin
        if (r < 25) return 0;
        if (r < 90) return $urandom_range(1, 6);
        return $urandom_range(20, 60);
      end
    endcase
  endfunction

  // One sample transfer; start stays high afterward so samples can go back to back.
  task automatic push_sample(logic [IN_W-1:0] sx, logic [IN_W-1:0] sy, logic [IN_W-1:0] sz);
    start       <= 1'b1;
    in_sample_x <= sx;
    in_sample_y <= sy;
    in_sample_z <= sz;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic hold_off(int cycles);
    if (cycles > 0) begin
      start <= 1'b0;
      repeat (cycles) @(negedge clk);
    end
  endtask

  // One register transfer, optionally preceded by idle cycles.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] word, int gap);
    if (gap > 0) begin
      cfg_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= word;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Loads every register once the pipeline has drained.
  task automatic load_model(erj_model_t m, bit poke_unused);
    start <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    write_reg(REG_CENTER, {m.center_z, m.center_y, m.center_x}, $urandom_range(0, 2));
    write_reg(REG_COEF_A, {spare_bits(), m.coef_a}, $urandom_range(0, 2));
    write_reg(REG_COEF_B, {spare_bits(), m.coef_b}, $urandom_range(0, 2));
    write_reg(REG_COEF_C, {spare_bits(), m.coef_c}, $urandom_range(0, 2));
    write_reg(REG_CROSS_UV, {spare_bits(), m.cross_uv}, $urandom_range(0, 2));
    write_reg(REG_CROSS_UW, {spare_bits(), m.cross_uw}, $urandom_range(0, 2));
    write_reg(REG_CROSS_VW, {spare_bits(), m.cross_vw}, $urandom_range(0, 2));
    if (poke_unused) begin
      write_reg(REG_NONE, CFG_DATA_W'({$urandom, $urandom}), $urandom_range(0, 2));
    end
    cfg_valid <= 1'b0;
    model_now = m;
    @(negedge clk);
  endtask

  initial begin
    int phase, n, count, pick;
    logic [IN_W-1:0] sx, sy, sz;
    rst_n       = 1'b0;
    start       = 1'b0;
    in_sample_x = '0;
    in_sample_y = '0;
    in_sample_z = '0;
    cfg_valid   = 1'b0;
    cfg_index   = '0;
    cfg_data    = '0;
    model_now   = '0;
    radius      = 1000;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset model: every coefficient zero, so the residual is exactly minus one.
    push_sample('0, '0, '0);
    push_sample(IN_W'(AXIS_MIN), IN_W'(AXIS_MIN), IN_W'(AXIS_MIN));
    push_sample(IN_W'(AXIS_MAX), IN_W'(AXIS_MAX), IN_W'(AXIS_MAX));
    push_sample(IN_W'(1), '1, '0);

    // Largest coefficients and wide offsets: residual saturates high, but for the sample on the center.
    load_model(make_model(IN_W'(AXIS_MAX), IN_W'(AXIS_MAX), IN_W'(AXIS_MAX),
                          32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                          32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF), 1'b0);
    push_sample(IN_W'(AXIS_MIN), IN_W'(AXIS_MIN), IN_W'(AXIS_MIN));
    push_sample(IN_W'(AXIS_MAX), IN_W'(AXIS_MAX), IN_W'(AXIS_MAX));
    push_sample(IN_W'(AXIS_MIN), IN_W'(AXIS_MAX), IN_W'(AXIS_MIN));

    // Most negative coefficients: residual saturates low, but for the sample on the center.
    load_model(make_model(IN_W'(AXIS_MIN), IN_W'(AXIS_MIN), IN_W'(AXIS_MIN),
                          32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                          32'h8000_0000, 32'h8000_0000, 32'h8000_0000), 1'b0);
    push_sample(IN_W'(AXIS_MAX), IN_W'(AXIS_MAX), IN_W'(AXIS_MAX));
    push_sample(IN_W'(AXIS_MAX), IN_W'(AXIS_MIN), IN_W'(AXIS_MAX));
    push_sample(IN_W'(AXIS_MIN), IN_W'(AXIS_MIN), IN_W'(AXIS_MIN));

    // Coefficients of magnitude one or zero: the right shift must round toward minus infinity.
    load_model(make_model('0, '0, '0, 32'd1, '1, '0, '1, 32'd1, '0), 1'b0);
    push_sample(IN_W'(1), '0, '0);
    push_sample('0, IN_W'(1), '0);
    push_sample(IN_W'(AXIS_MIN), IN_W'(AXIS_MAX), IN_W'(1));

    // Same model again plus a write to the unused index, which must change nothing.
    load_model(model_now, 1'b1);
    push_sample(IN_W'(AXIS_MAX), '1, IN_W'(AXIS_MIN));

    // Sphere of radius 1000: points on the axes give a residual near zero, the center minus one.
    radius = 1000;
    load_model(make_model(IN_W'(100), IN_W'(-200), IN_W'(300), 32'd1099511, 32'd1099511,
                          32'd1099511, '0, '0, '0), 1'b0);
    push_sample(IN_W'(1100), IN_W'(-200), IN_W'(300));
    push_sample(IN_W'(100), IN_W'(800), IN_W'(300));
    push_sample(IN_W'(100), IN_W'(-200), IN_W'(-700));
    push_sample(IN_W'(100), IN_W'(-200), IN_W'(300));

    // Random phases: a new model each time, then samples under one pacing profile.
    for (phase = 0; phase < 14; phase++) begin
      load_model(random_model(), $urandom_range(0, 3) == 0);
      count = $urandom_range(80, 120);
      for (n = 0; n < count; n++) begin
        hold_off(pick_gap(phase % 3));
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
          push_sample(IN_W'($urandom), IN_W'($urandom), IN_W'($urandom));
        end else if (pick < 55) begin
          push_sample(corner_axis(), corner_axis(), corner_axis());
        end else begin
          surface_sample(sx, sy, sz);
          push_sample(sx, sy, sz);
        end
      end
    end

    // Drain, then leave room for any stray result.
    start <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (RESULT_SLACK) @(negedge clk);
    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
